FILE: rtl/core/cc20_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 keystream package
// Shared types, register indexes and the state setup used by the pipeline.
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int DOUBLE_ROUNDS = 10;
	// Every double round is a column round and a diagonal round, each split
	// into two half quarter-round stages.
	localparam int NUM_STAGES = 4 * DOUBLE_ROUNDS;

	localparam logic [31:0] SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

	localparam logic [6:0] MAX_BYTES = 7'd64;

	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD0  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD1  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD2  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD3  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_LOW  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_HIGH = 3'd5;

	typedef logic [15:0][31:0] state_t;

	typedef struct packed {
		logic [31:0] block_counter;
		logic [6:0]  valid_bytes;
	} cmd_t;

	typedef struct packed {
		logic [63:0] stream_word0;
		logic [63:0] stream_word1;
		logic [63:0] stream_word2;
		logic [63:0] stream_word3;
		logic [63:0] stream_word4;
		logic [63:0] stream_word5;
		logic [63:0] stream_word6;
		logic [63:0] stream_word7;
		logic [6:0]  bytes_valid;
	} ks_t;

	typedef struct packed {
		logic [7:0][31:0] key;
		logic [2:0][31:0] nonce;
	} cfg_t;

	typedef struct packed {
		state_t      state;
		logic [31:0] counter;
		logic [6:0]  count;
	} pipe_t;

	// Word index of one quarter-round operand. Role 0..3 selects a, b, c, d.
	// The diagonal round shifts row r of the matrix by r lanes.
	function automatic logic [3:0] qr_index(input logic diag, input logic [1:0] lane,
		input logic [1:0] role);
		logic [1:0] col;
		begin
			col = lane + (diag ? role : 2'd0);
			return {role, col};
		end
	endfunction

	function automatic state_t init_state(input cfg_t cfg, input logic [31:0] counter);
		state_t s;
		begin
			s[0] = SIGMA0;
			s[1] = SIGMA1;
			s[2] = SIGMA2;
			s[3] = SIGMA3;
			for (int i = 0; i < 8; i++) begin
				s[4 + i] = cfg.key[i];
			end
			s[12] = counter;
			s[13] = cfg.nonce[0];
			s[14] = cfg.nonce[1];
			s[15] = cfg.nonce[2];
			return s;
		end
	endfunction

endpackage

FILE: rtl/core/chacha20_keystream_block.sv
// ----------------------------------------------------------------------------
// ChaCha20 keystream block
// Top level: configuration registers, half-round pipeline and output stage.
// ----------------------------------------------------------------------------
// The block accepts one command (block counter and byte count) per clock and
// returns one 64-byte keystream block per clock for as long as the consumer
// keeps ks_ready high. Every half quarter-round, two dependent 32-bit adds
// with their xor-rotates, takes one pipeline stage, and the final add of the
// initial state with byte masking fills the output register. The whole
// pipeline advances together; when the output register holds a transaction
// that is not taken, every stage holds and cmd_ready is low. Key and nonce
// are read live by the pipeline, so they must only be written while no
// transaction is in flight. Byte counts above 64 are treated as 64.
module chacha20_keystream_block (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [cc20_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_wdata,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  cc20_pkg::cmd_t                  cmd,
	output logic                            ks_valid,
	input  logic                            ks_ready,
	output cc20_pkg::ks_t                   ks
);
	import cc20_pkg::*;

	cfg_t       cfg;
	logic       advance;
	logic [6:0] count;
	logic       stage_valid [0:NUM_STAGES];
	pipe_t      stage_data  [0:NUM_STAGES];

	cc20_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign advance   = !ks_valid || ks_ready;
	assign cmd_ready = advance;

	assign count = (cmd.valid_bytes > MAX_BYTES) ? MAX_BYTES : cmd.valid_bytes;

	assign stage_valid[0]         = cmd_valid;
	assign stage_data[0].state    = init_state(cfg, cmd.block_counter);
	assign stage_data[0].counter  = cmd.block_counter;
	assign stage_data[0].count    = count;

	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_round
		cc20_half_round u_half (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (advance),
			.diag        (1'((k / 2) % 2)),
			.second_half (1'(k % 2)),
			.valid_in    (stage_valid[k]),
			.data_in     (stage_data[k]),
			.valid_out   (stage_valid[k+1]),
			.data_out    (stage_data[k+1])
		);
	end

	cc20_finalize u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.cfg       (cfg),
		.valid_in  (stage_valid[NUM_STAGES]),
		.data_in   (stage_data[NUM_STAGES]),
		.valid_out (ks_valid),
		.data_out  (ks)
	);

endmodule

FILE: rtl/core/cc20_cfg_regs.sv
// ----------------------------------------------------------------------------
// ChaCha20 configuration registers
// Holds the 256-bit key and the 96-bit nonce written through the write port.
// ----------------------------------------------------------------------------
module cc20_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [cc20_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_wdata,
	output cc20_pkg::cfg_t                  cfg
);
	import cc20_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_KEY_WORD0: begin
					cfg_q.key[0] <= cfg_wdata[31:0];
					cfg_q.key[1] <= cfg_wdata[63:32];
				end
				CFG_KEY_WORD1: begin
					cfg_q.key[2] <= cfg_wdata[31:0];
					cfg_q.key[3] <= cfg_wdata[63:32];
				end
				CFG_KEY_WORD2: begin
					cfg_q.key[4] <= cfg_wdata[31:0];
					cfg_q.key[5] <= cfg_wdata[63:32];
				end
				CFG_KEY_WORD3: begin
					cfg_q.key[6] <= cfg_wdata[31:0];
					cfg_q.key[7] <= cfg_wdata[63:32];
				end
				CFG_NONCE_LOW: begin
					cfg_q.nonce[0] <= cfg_wdata[31:0];
					cfg_q.nonce[1] <= cfg_wdata[63:32];
				end
				CFG_NONCE_HIGH: begin
					cfg_q.nonce[2] <= cfg_wdata[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/cc20_half_round.sv
// ----------------------------------------------------------------------------
// ChaCha20 half round stage
// Four parallel half quarter-rounds (two adds, two xor-rotates each), registered.
// ----------------------------------------------------------------------------
module cc20_half_round (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            diag,
	input  logic            second_half,
	input  logic            valid_in,
	input  cc20_pkg::pipe_t data_in,
	output logic            valid_out,
	output cc20_pkg::pipe_t data_out
);
	import cc20_pkg::*;

	pipe_t nxt;
	logic  valid_s1;
	pipe_t data_s1;

	always_comb begin
		logic [3:0]  ia, ib, ic, id;
		logic [31:0] a, b, c, d, x, y;
		nxt = data_in;
		for (int lane = 0; lane < 4; lane++) begin
			ia = qr_index(diag, 2'(lane), 2'd0);
			ib = qr_index(diag, 2'(lane), 2'd1);
			ic = qr_index(diag, 2'(lane), 2'd2);
			id = qr_index(diag, 2'(lane), 2'd3);
			a = data_in.state[ia] + data_in.state[ib];
			x = data_in.state[id] ^ a;
			d = second_half ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
			c = data_in.state[ic] + d;
			y = data_in.state[ib] ^ c;
			b = second_half ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
			nxt.state[ia] = a;
			nxt.state[ib] = b;
			nxt.state[ic] = c;
			nxt.state[id] = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign valid_out = valid_s1;
	assign data_out  = data_s1;

endmodule

FILE: rtl/core/cc20_finalize.sv
// ----------------------------------------------------------------------------
// ChaCha20 finalize stage
// Adds the initial state back, packs little-endian words and masks unused bytes.
// ----------------------------------------------------------------------------
module cc20_finalize (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  cc20_pkg::cfg_t  cfg,
	input  logic            valid_in,
	input  cc20_pkg::pipe_t data_in,
	output logic            valid_out,
	output cc20_pkg::ks_t   data_out
);
	import cc20_pkg::*;

	state_t            init;
	state_t            sum;
	logic [7:0][63:0]  words;
	ks_t               nxt;
	logic              valid_q;
	ks_t               data_q;

	// The user must not change the key and nonce while a block is in flight
	// (the block does not enforce this); the initial state is rebuilt here from the live registers.
	assign init = init_state(cfg, data_in.counter);

	always_comb begin
		logic [63:0] pair;
		for (int i = 0; i < 16; i++) begin
			sum[i] = data_in.state[i] + init[i];
		end
		for (int w = 0; w < 8; w++) begin
			pair = {sum[2*w+1], sum[2*w]};
			for (int b = 0; b < 8; b++) begin
				words[w][8*b +: 8] = (7'(8*w + b) < data_in.count) ? pair[8*b +: 8] : 8'h00;
			end
		end
		nxt.stream_word0 = words[0];
		nxt.stream_word1 = words[1];
		nxt.stream_word2 = words[2];
		nxt.stream_word3 = words[3];
		nxt.stream_word4 = words[4];
		nxt.stream_word5 = words[5];
		nxt.stream_word6 = words[6];
		nxt.stream_word7 = words[7];
		nxt.bytes_valid  = data_in.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign valid_out = valid_q;
	assign data_out  = data_q;

endmodule
